// ===== hdl/galc_pkg.sv =====
// galc_pkg: shared constants for the glyph atlas slot cache
// field widths, parameter defaults and register reset values
// no dependencies
`default_nettype none

package galc_pkg;

   // parameter defaults
   localparam int SIDE_DEFAULT       = 8;
   localparam int GLYPH_BITS_DEFAULT = 16;

   // fixed port field widths
   localparam int GLYPH_W    = 16;
   localparam int SLOT_NUM_W = 6;
   localparam int COORD_W    = 12;
   localparam int SLOT_PIX_W = 10;

   // slot size register reset and coordinate ceiling
   localparam logic [SLOT_PIX_W-1:0] SLOT_PIX_RESET = 10'd32;
   localparam int COORD_MAX = 4095;

endpackage

`default_nettype wire

// ===== hdl/glyph_atlas_slot_lru_cache.sv =====
// glyph_atlas_slot_lru_cache: fully associative atlas slot cache, lru replacement
// a lookup scans the occupied slots until a match (one tag ram read per cycle),
// then finds the slot row by repeated subtraction (one subtract per cycle)
// throughput: one request at a time; the next is taken once the result is registered
// reset (synchronous): cache empty, recency chain empty, slot size 32; no memory sweep
`default_nettype none

module glyph_atlas_slot_lru_cache
   import galc_pkg::*;
#(
   parameter int SLOTS_PER_SIDE = SIDE_DEFAULT,
   parameter int GLYPH_BITS     = GLYPH_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [GLYPH_W-1:0]    req_glyph_id,
   input  wire logic                  csr_we,
   input  wire logic [SLOT_PIX_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SLOT_NUM_W-1:0]      rsp_slot_number,
   output logic [COORD_W-1:0]         rsp_slot_x,
   output logic [COORD_W-1:0]         rsp_slot_y,
   output logic                       rsp_was_hit,
   output logic                       rsp_did_evict,
   output logic [GLYPH_W-1:0]         rsp_victim_glyph
);

   localparam int SLOTS  = SLOTS_PER_SIDE * SLOTS_PER_SIDE;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SIDE_W = (SLOTS_PER_SIDE > 1) ? $clog2(SLOTS_PER_SIDE) : 1;
   localparam int PROD_W = SIDE_W + SLOT_PIX_W;
   localparam logic [CNT_W-1:0] HEAD = CNT_W'(SLOTS);
   localparam logic [IDX_W-1:0] SIDE_STEP = IDX_W'(SLOTS_PER_SIDE);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_SCAN    = 9'b000000010,
      ST_DECIDE  = 9'b000000100,
      ST_LINK_RD = 9'b000001000,
      ST_UNLINK  = 9'b000010000,
      ST_MK_OLD  = 9'b000100000,
      ST_MK_NEW  = 9'b001000000,
      ST_DIVIDE  = 9'b010000000,
      ST_COORD   = 9'b100000000
   } state_type;

   // control registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  free_left_ff, free_left_in;
   logic [CNT_W-1:0]  head_newer_ff, head_newer_in;
   logic [CNT_W-1:0]  head_older_ff, head_older_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_PIX_W-1:0] slot_pixels_ff, slot_pixels_in;

   // working registers
   logic [GLYPH_BITS-1:0] tag_ff, tag_in;
   logic [GLYPH_BITS-1:0] victim_ff, victim_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]      s_ff, s_in;
   logic [CNT_W-1:0]      m_ff, m_in;
   logic [IDX_W-1:0]      rem_ff, rem_in;
   logic [SIDE_W-1:0]     row_ff, row_in;
   logic                  hit_ff, hit_in;
   logic                  evict_ff, evict_in;
   logic                  fresh_ff, fresh_in;

   // result registers
   logic [SLOT_NUM_W-1:0] rsp_slot_number_ff, rsp_slot_number_in;
   logic [COORD_W-1:0]    rsp_slot_x_ff, rsp_slot_x_in;
   logic [COORD_W-1:0]    rsp_slot_y_ff, rsp_slot_y_in;
   logic                  rsp_was_hit_ff, rsp_was_hit_in;
   logic                  rsp_did_evict_ff, rsp_did_evict_in;
   logic [GLYPH_W-1:0]    rsp_victim_glyph_ff, rsp_victim_glyph_in;

   // ram ports
   logic                  tag_we;
   logic [IDX_W-1:0]      tag_addr;
   logic [GLYPH_BITS-1:0] tag_q;
   logic                  newer_we, older_we;
   logic [IDX_W-1:0]      newer_addr, older_addr;
   logic [CNT_W-1:0]      newer_wdata, older_wdata;
   logic [CNT_W-1:0]      newer_q, older_q;

   // datapath helpers
   logic                  tag_match;
   logic [CNT_W-1:0]      free_dec;
   logic [IDX_W-1:0]      lru_slot;
   logic [PROD_W-1:0]     prod_x, prod_y;
   logic                  out_free;

   assign tag_match = cmp_vld_ff && (tag_q == tag_ff);
   assign free_dec  = free_left_ff - 1'b1;
   assign lru_slot  = (head_newer_ff >= HEAD) ? '0 : head_newer_ff[IDX_W-1:0];
   assign prod_x    = PROD_W'(rem_ff[SIDE_W-1:0]) * PROD_W'(slot_pixels_ff);
   assign prod_y    = PROD_W'(row_ff) * PROD_W'(slot_pixels_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // tag store and recency chain links (head entry kept in flops)
   galc_ram #(.WIDTH(GLYPH_BITS), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .addr    (tag_addr),
      .wr_data (tag_ff),
      .rd_data (tag_q)
   );

   galc_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_newer_ram (
      .clock   (clock),
      .wr_en   (newer_we),
      .addr    (newer_addr),
      .wr_data (newer_wdata),
      .rd_data (newer_q)
   );

   galc_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_older_ram (
      .clock   (clock),
      .wr_en   (older_we),
      .addr    (older_addr),
      .wr_data (older_wdata),
      .rd_data (older_q)
   );

   // sequencer and next values
   always_comb begin
      state_in            = state_ff;
      free_left_in        = free_left_ff;
      head_newer_in       = head_newer_ff;
      head_older_in       = head_older_ff;
      scan_in             = scan_ff;
      cmp_vld_in          = cmp_vld_ff;
      cmp_idx_in          = cmp_idx_ff;
      tag_in              = tag_ff;
      victim_in           = victim_ff;
      s_in                = s_ff;
      m_in                = m_ff;
      rem_in              = rem_ff;
      row_in              = row_ff;
      hit_in              = hit_ff;
      evict_in            = evict_ff;
      fresh_in            = fresh_ff;
      slot_pixels_in      = csr_we ? csr_wdata : slot_pixels_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_slot_number_in  = rsp_slot_number_ff;
      rsp_slot_x_in       = rsp_slot_x_ff;
      rsp_slot_y_in       = rsp_slot_y_ff;
      rsp_was_hit_in      = rsp_was_hit_ff;
      rsp_did_evict_in    = rsp_did_evict_ff;
      rsp_victim_glyph_in = rsp_victim_glyph_ff;
      tag_we              = 1'b0;
      tag_addr            = s_ff;
      newer_we            = 1'b0;
      newer_addr          = s_ff;
      newer_wdata         = HEAD;
      older_we            = 1'b0;
      older_addr          = s_ff;
      older_wdata         = head_older_ff;

      case (state_ff)
         // take a request, scan starts at the lowest occupied slot
         ST_IDLE: begin
            if (req_valid) begin
               tag_in     = GLYPH_BITS'(req_glyph_id);
               scan_in    = free_left_ff;
               cmp_vld_in = 1'b0;
               hit_in     = 1'b0;
               evict_in   = 1'b0;
               fresh_in   = 1'b0;
               victim_in  = '0;
               state_in   = ST_SCAN;
            end
         end
         // one tag read and one compare per cycle
         ST_SCAN: begin
            tag_addr = scan_ff[IDX_W-1:0];
            if (tag_match) begin
               hit_in   = 1'b1;
               s_in     = cmp_idx_ff;
               state_in = ST_DECIDE;
            end else if (scan_ff == HEAD && !cmp_vld_ff) begin
               state_in = ST_DECIDE;
            end else begin
               cmp_vld_in = (scan_ff != HEAD);
               cmp_idx_in = scan_ff[IDX_W-1:0];
               if (scan_ff != HEAD) begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         // hit, fresh slot or eviction of the oldest
         ST_DECIDE: begin
            if (hit_ff) begin
               state_in = ST_LINK_RD;
            end else if (free_left_ff != '0) begin
               fresh_in     = 1'b1;
               s_in         = free_dec[IDX_W-1:0];
               free_left_in = free_dec;
               state_in     = ST_MK_OLD;
            end else begin
               evict_in = 1'b1;
               s_in     = lru_slot;
               state_in = ST_LINK_RD;
            end
         end
         // fetch links and old tag of the slot
         ST_LINK_RD: begin
            state_in = ST_UNLINK;
         end
         // splice the slot out of the chain, retag on eviction
         ST_UNLINK: begin
            if (evict_ff) begin
               victim_in = tag_q;
               tag_we    = 1'b1;
            end
            older_addr  = newer_q[IDX_W-1:0];
            older_wdata = older_q;
            older_we    = (newer_q != HEAD);
            newer_addr  = older_q[IDX_W-1:0];
            newer_wdata = newer_q;
            newer_we    = (older_q != HEAD);
            if (newer_q == HEAD) begin
               head_older_in = older_q;
            end
            if (older_q == HEAD) begin
               head_newer_in = newer_q;
            end
            state_in = ST_MK_OLD;
         end
         // link the slot in at the newest end
         ST_MK_OLD: begin
            tag_we        = fresh_ff;
            older_we      = 1'b1;
            older_wdata   = head_older_ff;
            newer_we      = 1'b1;
            newer_wdata   = HEAD;
            m_in          = head_older_ff;
            head_older_in = CNT_W'(s_ff);
            state_in      = ST_MK_NEW;
         end
         ST_MK_NEW: begin
            if (m_ff != HEAD) begin
               newer_we    = 1'b1;
               newer_addr  = m_ff[IDX_W-1:0];
               newer_wdata = CNT_W'(s_ff);
            end else begin
               head_newer_in = CNT_W'(s_ff);
            end
            rem_in   = s_ff;
            row_in   = '0;
            state_in = ST_DIVIDE;
         end
         // row and column by repeated subtraction
         ST_DIVIDE: begin
            if (32'(rem_ff) >= SLOTS_PER_SIDE) begin
               rem_in = rem_ff - SIDE_STEP;
               row_in = row_ff + 1'b1;
            end else begin
               state_in = ST_COORD;
            end
         end
         // pixel coordinates into the result register
         ST_COORD: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_slot_number_in  = SLOT_NUM_W'(s_ff);
               rsp_slot_x_in       = (32'(prod_x) > COORD_MAX) ?
                                     COORD_W'(COORD_MAX) : COORD_W'(prod_x);
               rsp_slot_y_in       = (32'(prod_y) > COORD_MAX) ?
                                     COORD_W'(COORD_MAX) : COORD_W'(prod_y);
               rsp_was_hit_in      = hit_ff;
               rsp_did_evict_in    = evict_ff;
               rsp_victim_glyph_in = GLYPH_W'(victim_ff);
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         free_left_ff   <= HEAD;
         head_newer_ff  <= HEAD;
         head_older_ff  <= HEAD;
         scan_ff        <= '0;
         cmp_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         slot_pixels_ff <= SLOT_PIX_RESET;
      end else begin
         state_ff       <= state_in;
         free_left_ff   <= free_left_in;
         head_newer_ff  <= head_newer_in;
         head_older_ff  <= head_older_in;
         scan_ff        <= scan_in;
         cmp_vld_ff     <= cmp_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot_pixels_ff <= slot_pixels_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      tag_ff              <= tag_in;
      victim_ff           <= victim_in;
      cmp_idx_ff          <= cmp_idx_in;
      s_ff                <= s_in;
      m_ff                <= m_in;
      rem_ff              <= rem_in;
      row_ff              <= row_in;
      hit_ff              <= hit_in;
      evict_ff            <= evict_in;
      fresh_ff            <= fresh_in;
      rsp_slot_number_ff  <= rsp_slot_number_in;
      rsp_slot_x_ff       <= rsp_slot_x_in;
      rsp_slot_y_ff       <= rsp_slot_y_in;
      rsp_was_hit_ff      <= rsp_was_hit_in;
      rsp_did_evict_ff    <= rsp_did_evict_in;
      rsp_victim_glyph_ff <= rsp_victim_glyph_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_number  = rsp_slot_number_ff;
   assign rsp_slot_x       = rsp_slot_x_ff;
   assign rsp_slot_y       = rsp_slot_y_ff;
   assign rsp_was_hit      = rsp_was_hit_ff;
   assign rsp_did_evict    = rsp_did_evict_ff;
   assign rsp_victim_glyph = rsp_victim_glyph_ff;

`ifndef SYNTHESIS
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_left_ff <= HEAD)
      else $error("free slot count beyond slot total");

   a_rsp_from_coord: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COORD))
      else $error("response raised outside coordinate step");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SCAN)
      else $error("accepted request did not start a scan");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_did_evict_ff |-> free_left_ff == '0)
      else $error("eviction while free slots remain");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_was_hit_ff && rsp_did_evict_ff))
      else $error("hit and eviction reported together");
`endif

endmodule

`default_nettype wire

// ===== hdl/galc_ram.sv =====
// galc_ram: generic single port ram with registered read
// one address serves both the write and the read; no dependencies
`default_nettype none

module galc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== tb/glyph_atlas_slot_lru_cache_tb.sv =====
// glyph_atlas_slot_lru_cache_tb: self-checking bench for the atlas slot cache
// predicts slot, coordinates, hit and eviction per request and compares them
// depends on galc_pkg and glyph_atlas_slot_lru_cache
`timescale 1ns / 100ps

module glyph_atlas_slot_lru_cache_tb;
   import galc_pkg::*;

   localparam int SIDE       = SIDE_DEFAULT;
   localparam int TAG_BITS   = GLYPH_BITS_DEFAULT;
   localparam int SLOTS      = SIDE * SIDE;
   localparam int HEAD       = SLOTS;
   localparam logic [63:0] TAG_MASK = (64'd1 << TAG_BITS) - 64'd1;
   localparam int MAX_GAP     = 18;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 500;
   localparam int DRAIN_WAIT  = 100;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_LEN   = 175;

   typedef struct packed {
      logic [SLOT_NUM_W-1:0] slot;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic                  hit;
      logic                  evict;
      logic [GLYPH_W-1:0]    victim;
   } placement_type;

   // predicted cache contents, recency chain and expected placements
   class slot_cache_model;
      logic [GLYPH_W-1:0]    tags [SLOTS];
      bit                    valid [SLOTS];
      int                    newer [SLOTS+1];
      int                    older [SLOTS+1];
      int                    free_left;
      logic [SLOT_PIX_W-1:0] pix;
      placement_type         placements_due [$];
      int                    errors;

      function new();
         int i;
         for (i = 0; i < SLOTS; i++) begin
            tags[i]  = '0;
            valid[i] = 1'b0;
         end
         for (i = 0; i <= SLOTS; i++) begin
            newer[i] = HEAD;
            older[i] = HEAD;
         end
         free_left = SLOTS;
         pix       = SLOT_PIX_RESET;
         errors    = 0;
      endfunction

      function void set_pixels(logic [SLOT_PIX_W-1:0] v);
         pix = v;
      endfunction

      function void unlink(int s);
         int n;
         int o;
         n = newer[s];
         o = older[s];
         older[n] = o;
         newer[o] = n;
      endfunction

      function void make_newest(int s);
         int m;
         m = older[HEAD];
         older[s]    = m;
         newer[s]    = HEAD;
         newer[m]    = s;
         older[HEAD] = s;
      endfunction

      // position times slot size, saturated to the coordinate ceiling
      function logic [COORD_W-1:0] coord(int pos);
         longint v;
         v = longint'(pos) * longint'(pix);
         if (v > COORD_MAX)
            return COORD_W'(COORD_MAX);
         return COORD_W'(v);
      endfunction

      // accepted request: look up, update the chain and queue the placement
      function void note_lookup(logic [GLYPH_W-1:0] glyph);
         logic [GLYPH_W-1:0] tag;
         int                 s;
         int                 i;
         bit                 hit;
         placement_type      p;
         tag = glyph & TAG_MASK[GLYPH_W-1:0];
         s   = 0;
         hit = 1'b0;
         p   = '0;
         for (i = 0; i < SLOTS; i++) begin
            if (!hit && valid[i] && tags[i] == tag) begin
               s   = i;
               hit = 1'b1;
            end
         end
         if (hit) begin
            unlink(s);
         end else if (free_left > 0) begin
            free_left--;
            s        = free_left;
            valid[s] = 1'b1;
            tags[s]  = tag;
         end else begin
            // evict the oldest slot
            s        = newer[HEAD];
            p.evict  = 1'b1;
            p.victim = tags[s];
            unlink(s);
            tags[s]  = tag;
            valid[s] = 1'b1;
         end
         make_newest(s);
         p.slot = SLOT_NUM_W'(s);
         p.x    = coord(s % SIDE);
         p.y    = coord(s / SIDE);
         p.hit  = hit;
         placements_due.push_back(p);
      endfunction

      task flag_mismatch(string what, longint got_v, longint want_v);
         $display("mismatch %s: got %0d, want %0d", what, got_v, want_v);
         errors++;
      endtask

      // accepted result against the oldest expected placement
      task check_placement(placement_type got);
         placement_type want;
         if (placements_due.size() == 0) begin
            flag_mismatch("result with nothing expected, slot", got.slot, -1);
         end else begin
            want = placements_due.pop_front();
            if (got.slot !== want.slot)
               flag_mismatch("slot_number", got.slot, want.slot);
            if (got.x !== want.x)
               flag_mismatch("slot_x", got.x, want.x);
            if (got.y !== want.y)
               flag_mismatch("slot_y", got.y, want.y);
            if (got.hit !== want.hit)
               flag_mismatch("was_hit", got.hit, want.hit);
            if (got.evict !== want.evict)
               flag_mismatch("did_evict", got.evict, want.evict);
            if (got.victim !== want.victim)
               flag_mismatch("victim_glyph", got.victim, want.victim);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [GLYPH_W-1:0]    req_glyph_id;
   logic                  csr_we;
   logic [SLOT_PIX_W-1:0] csr_wdata;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SLOT_NUM_W-1:0] rsp_slot_number;
   logic [COORD_W-1:0]    rsp_slot_x;
   logic [COORD_W-1:0]    rsp_slot_y;
   logic                  rsp_was_hit;
   logic                  rsp_did_evict;
   logic [GLYPH_W-1:0]    rsp_victim_glyph;

   slot_cache_model model = new();
   bit              calm;
   int              cycles;

   glyph_atlas_slot_lru_cache uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_glyph_id     (req_glyph_id),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_number  (rsp_slot_number),
      .rsp_slot_x       (rsp_slot_x),
      .rsp_slot_y       (rsp_slot_y),
      .rsp_was_hit      (rsp_was_hit),
      .rsp_did_evict    (rsp_did_evict),
      .rsp_victim_glyph (rsp_victim_glyph)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("glyph_atlas_slot_lru_cache_tb: done, errors");
         $finish;
      end
   end

   function int draw_gap();
      if (calm)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // offer one request and wait for it to be taken
   task send_glyph(logic [GLYPH_W-1:0] glyph);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_glyph_id <= glyph;
      do @(posedge clock); while (!req_ready);
      model.note_lookup(glyph);
   endtask

   // slot size write once every result is back
   task set_slot_pixels(logic [SLOT_PIX_W-1:0] v);
      req_valid <= 1'b0;
      while (model.placements_due.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      model.set_pixels(v);
   endtask

   // mostly a working set around base, some wider sets that force eviction
   task run_random(int n, logic [GLYPH_W-1:0] base);
      int                 i;
      int                 pick;
      logic [GLYPH_W-1:0] glyph;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            glyph = base + GLYPH_W'($urandom_range(0, 47));
         else if (pick < 8)
            glyph = base + GLYPH_W'($urandom_range(0, 95));
         else
            glyph = GLYPH_W'($urandom_range(0, 65535));
         send_glyph(glyph);
      end
   endtask

   // result side, with one long hold-off to back up the request side
   initial begin
      int  gap;
      int  taken;
      bit  held;
      placement_type got;
      taken = 0;
      held  = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = draw_gap();
         if (taken == HOLD_AT && !held) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.slot   = rsp_slot_number;
         got.x      = rsp_slot_x;
         got.y      = rsp_slot_y;
         got.hit    = rsp_was_hit;
         got.evict  = rsp_did_evict;
         got.victim = rsp_victim_glyph;
         model.check_placement(got);
         taken++;
      end
   end

   // request side and phases
   initial begin
      logic [SLOT_PIX_W-1:0] pix_list [8];
      int                    k;
      cycles       <= 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_glyph_id <= '0;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      calm = 1'b0;
      pix_list = '{10'd32, 10'd1, 10'd512, 10'd1023, 10'd0, 10'd7, 10'd100, 10'd0};
      pix_list[7] = SLOT_PIX_W'($urandom_range(0, 1023));
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and repeat lookups at the reset slot size
      send_glyph(16'h0000);
      send_glyph(16'hFFFF);
      send_glyph(16'h0000);
      send_glyph(16'hFFFF);
      send_glyph(16'h5555);
      send_glyph(16'hAAAA);
      send_glyph(16'h0001);
      send_glyph(16'h8000);
      send_glyph(16'h7FFF);
      send_glyph(16'h0000);
      // oversized slot size, coordinates saturate
      set_slot_pixels(10'd1023);
      send_glyph(16'h0000);
      send_glyph(16'h1234);
      send_glyph(16'h5555);
      // zero slot size
      set_slot_pixels(10'd0);
      send_glyph(16'hFFFF);
      send_glyph(16'h4321);
      // a mid-range size without saturation and the smallest nonzero size
      set_slot_pixels(10'd512);
      send_glyph(16'h0000);
      send_glyph(16'hBEEF);
      set_slot_pixels(10'd1);
      send_glyph(16'h8000);
      send_glyph(16'h00FF);

      // random phases across several slot sizes
      for (k = 0; k < 8; k++) begin
         set_slot_pixels(pix_list[k]);
         calm = (k == 2) || ($urandom_range(0, 3) == 0);
         run_random(PHASE_LEN, GLYPH_W'($urandom_range(0, 65535 - 96)));
      end

      // drain and settle
      req_valid <= 1'b0;
      while (model.placements_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (model.errors == 0)
         $display("glyph_atlas_slot_lru_cache_tb: done, clean");
      else
         $display("glyph_atlas_slot_lru_cache_tb: done, errors");
      $finish;
   end

endmodule
